>>> rtl/midpoint_circle_points_top_assert.svh
// assertion macros for the circle point generator checker
`ifndef MIDPOINT_CIRCLE_POINTS_TOP_ASSERT_SVH
`define MIDPOINT_CIRCLE_POINTS_TOP_ASSERT_SVH

// same-cycle implication
`define MCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mcp_pkg.sv
package mcp_pkg;

    localparam int COORD_W = 15;
    localparam int RAD_W   = 4;
    localparam int PT_W    = 16;
    localparam int OCT_W   = 3;

    localparam logic [OCT_W-1:0] OCT_LAST = 3'd7;

    typedef enum logic {
        MCP_IDLE,
        MCP_RUN
    } mcp_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } mcp_cmd_t;

    typedef struct packed {
        logic last;
    } mcp_status_t;

endpackage

>>> rtl/mcp_ifs.sv
interface mcp_req_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mcp_pkg::COORD_W-1:0]        center_x;
    logic signed [mcp_pkg::COORD_W-1:0]        center_y;
    logic        [mcp_pkg::RAD_W-1:0]          radius;

    modport source (output valid, output center_x, output center_y, output radius,
                    input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    output ready);
endinterface

interface mcp_point_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [mcp_pkg::PT_W-1:0]           point_x;
    logic signed [mcp_pkg::PT_W-1:0]           point_y;
    logic                                      last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

>>> rtl/mcp_ctrl.sv
module mcp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mcp_pkg::mcp_status_t status,
    output mcp_pkg::mcp_cmd_t    cmd
);

    mcp_pkg::mcp_state_t state_reg;
    mcp_pkg::mcp_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcp_pkg::MCP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            mcp_pkg::MCP_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mcp_pkg::MCP_RUN;
                end
            end
            mcp_pkg::MCP_RUN:
            begin
                // emit when the output slot is empty or draining
                if (!out_valid_reg || out_ready)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last)
                    begin
                        state_next = mcp_pkg::MCP_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mcp_pkg::MCP_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/mcp_dp.sv
module mcp_dp
#(
    parameter int MAX_RADIUS = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcp_pkg::mcp_cmd_t                   cmd,
    output mcp_pkg::mcp_status_t                status,
    input  logic signed [mcp_pkg::COORD_W-1:0]  center_x,
    input  logic signed [mcp_pkg::COORD_W-1:0]  center_y,
    input  logic        [mcp_pkg::RAD_W-1:0]    radius,
    output logic signed [mcp_pkg::PT_W-1:0]     point_x,
    output logic signed [mcp_pkg::PT_W-1:0]     point_y,
    output logic                                last_point
);

    localparam int OFF_W = $clog2(MAX_RADIUS + 2) + 1;
    localparam int ERR_W = OFF_W + 3;

    logic signed [OFF_W-1:0]           x_reg;
    logic signed [OFF_W-1:0]           y_reg;
    logic signed [ERR_W-1:0]           err_reg;
    logic        [mcp_pkg::OCT_W-1:0]  oct_reg;
    logic signed [mcp_pkg::COORD_W-1:0] cx_reg;
    logic signed [mcp_pkg::COORD_W-1:0] cy_reg;
    logic signed [mcp_pkg::PT_W-1:0]   px_reg;
    logic signed [mcp_pkg::PT_W-1:0]   py_reg;
    logic                              last_reg;

    logic        [mcp_pkg::RAD_W-1:0]  rad_c;
    logic signed [OFF_W-1:0]           x_next;
    logic signed [OFF_W-1:0]           y_next;
    logic signed [ERR_W-1:0]           err_next;
    logic signed [ERR_W-1:0]           xn_e;
    logic signed [ERR_W-1:0]           yn_e;
    logic signed [OFF_W-1:0]           off_x;
    logic signed [OFF_W-1:0]           off_y;
    logic signed [mcp_pkg::PT_W-1:0]   px_calc;
    logic signed [mcp_pkg::PT_W-1:0]   py_calc;
    logic                              iter_done;

    assign rad_c = (radius > mcp_pkg::RAD_W'(MAX_RADIUS)) ?
                   mcp_pkg::RAD_W'(MAX_RADIUS) : radius;

    // decision step at the end of an iteration
    always_comb
    begin
        y_next = y_reg + OFF_W'(1);
        x_next = err_reg[ERR_W-1] ? x_reg : x_reg - OFF_W'(1);
        xn_e   = ERR_W'(x_next);
        yn_e   = ERR_W'(y_next);
        if (err_reg[ERR_W-1])
        begin
            err_next = err_reg + (yn_e <<< 1) + ERR_W'(1);
        end
        else
        begin
            err_next = err_reg + ((yn_e - xn_e + ERR_W'(1)) <<< 1);
        end
    end

    assign iter_done   = (oct_reg == mcp_pkg::OCT_LAST);
    assign status.last = iter_done && (x_next < y_next);

    // symmetric point selection
    always_comb
    begin
        case (oct_reg)
            3'd0:    begin off_x = x_reg;  off_y = y_reg;  end
            3'd1:    begin off_x = y_reg;  off_y = x_reg;  end
            3'd2:    begin off_x = -x_reg; off_y = y_reg;  end
            3'd3:    begin off_x = -y_reg; off_y = x_reg;  end
            3'd4:    begin off_x = -x_reg; off_y = -y_reg; end
            3'd5:    begin off_x = -y_reg; off_y = -x_reg; end
            3'd6:    begin off_x = x_reg;  off_y = -y_reg; end
            default: begin off_x = y_reg;  off_y = -x_reg; end
        endcase
        px_calc = mcp_pkg::PT_W'(cx_reg) + mcp_pkg::PT_W'(off_x);
        py_calc = mcp_pkg::PT_W'(cy_reg) + mcp_pkg::PT_W'(off_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg <= '0;
        end
        else if (cmd.load)
        begin
            oct_reg <= '0;
        end
        else if (cmd.step)
        begin
            oct_reg <= oct_reg + mcp_pkg::OCT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            err_reg  <= '0;
            px_reg   <= '0;
            py_reg   <= '0;
            last_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            x_reg   <= OFF_W'(rad_c);
            y_reg   <= '0;
            err_reg <= ERR_W'(1) - ERR_W'(rad_c);
        end
        else if (cmd.step)
        begin
            px_reg   <= px_calc;
            py_reg   <= py_calc;
            last_reg <= status.last;
            if (iter_done)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                err_reg <= err_next;
            end
        end
    end

    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = last_reg;

endmodule

>>> rtl/midpoint_circle_points_top.sv
// Midpoint circle point generator. A request (center, radius) starts a run that
// sends every outline point, one point per cycle while the output is taken, eight
// points per midpoint iteration in the order (x,y) (y,x) (-x,y) (-y,x) (-x,-y)
// (-y,-x) (x,-y) (y,-x) around the center, with the final point marked by
// last_point. A radius above MAX_RADIUS is clamped to it; radius 0 gives eight
// copies of the center. A request is taken while the controller is idle; the
// points then come from the single point-select and add path stepped by the
// controller, and output stalls hold the run. The next request is taken once
// the last point enters the output register, while that point may still be
// waiting to transfer.
module midpoint_circle_points_top
#(
    parameter int MAX_RADIUS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    mcp_req_if.sink     req,
    mcp_point_if.source point
);

    mcp_pkg::mcp_cmd_t    cmd;
    mcp_pkg::mcp_status_t status;

    mcp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (point.valid),
        .out_ready (point.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mcp_dp #(.MAX_RADIUS(MAX_RADIUS)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .center_x   (req.center_x),
        .center_y   (req.center_y),
        .radius     (req.radius),
        .point_x    (point.point_x),
        .point_y    (point.point_y),
        .last_point (point.last_point)
    );

endmodule

>>> rtl/mcp_checker.sv
`include "midpoint_circle_points_top_assert.svh"

module mcp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [mcp_pkg::PT_W-1:0]   point_x,
    input logic signed [mcp_pkg::PT_W-1:0]   point_y,
    input logic                              last_point
);

    `MCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(point_x) && $stable(point_y) && $stable(last_point), "stalled point changed")
    `MCP_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while a run is active")
    `MCP_ASSERT_NOW(a_busy_only_on_req, clk, rst_n, $fell(in_ready), $past(in_valid && in_ready), "went busy without a request transfer")
    `MCP_ASSERT_NOW(a_idle_after_last, clk, rst_n, $rose(in_ready), out_valid && last_point, "run ended without a last point")

endmodule

bind midpoint_circle_points_top mcp_checker u_mcp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (point.valid),
    .out_ready  (point.ready),
    .point_x    (point.point_x),
    .point_y    (point.point_y),
    .last_point (point.last_point)
);
